// File: hw/rtl/asm_keyword_lexer_assert.svh
// assertion macros shared by the lexer modules
`ifndef ASM_KEYWORD_LEXER_ASSERT_SVH
`define ASM_KEYWORD_LEXER_ASSERT_SVH

// same-cycle implication, off during reset
`define AKL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lexer check failed");

// next-cycle implication, off during reset
`define AKL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

// File: hw/rtl/akl_pkg.sv
`default_nettype none

package akl_pkg;

  localparam int AKL_MAX_WORD_LEN  = 7;
  localparam int AKL_POSITION_BITS = 16;
  localparam int AKL_QUEUE_DEPTH   = 4;

  localparam int KW_COUNT     = 23;
  localparam int KW_MAX_CHARS = 6;
  localparam int KW_LEN_W     = 3;
  localparam int KW_CODE_W    = 5;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_WORD    = 2'd1,
    KIND_DIGIT   = 2'd2
  } akl_kind_t;

  // first character sits in the top byte
  typedef logic [8*KW_MAX_CHARS-1:0] kw_text_t;

  typedef struct packed {
    logic                 hit;
    logic [KW_CODE_W-1:0] code;
  } akl_hit_t;

  // one queue entry: a finished word and/or a digit token
  typedef struct packed {
    logic                 word_valid;
    akl_kind_t            word_kind;
    logic [KW_CODE_W-1:0] word_code;
    logic                 digit_valid;
  } akl_tag_t;

  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    {"nop", 24'h0}, {"push", 16'h0}, {"pop", 24'h0}, {"add", 24'h0},
    {"sub", 24'h0}, {"mul", 24'h0}, {"dup", 24'h0}, {"indup", 8'h0},
    {"swap", 16'h0}, "inswap", {"div", 24'h0}, {"mod", 24'h0},
    {"cmpe", 16'h0}, {"cmpne", 8'h0}, {"cmpg", 16'h0}, {"cmpl", 16'h0},
    {"cmpge", 8'h0}, {"cmple", 8'h0}, {"jmp", 24'h0}, {"zjmp", 16'h0},
    {"nzjmp", 8'h0}, {"print", 8'h0}, {"halt", 16'h0}
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd4, 3'd6, 3'd3, 3'd3,
    3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd3, 3'd4, 3'd5, 3'd5, 3'd4
  };

  // parallel compare against the whole mnemonic bank
  function automatic akl_hit_t kw_lookup(input kw_text_t text,
                                         input logic [KW_LEN_W-1:0] len);
    akl_hit_t r;
    logic     same;
    r.hit  = 1'b0;
    r.code = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      same = (len == KW_LEN[k]);
      for (int i = 0; i < KW_MAX_CHARS; i++) begin
        if (i < int'(len) &&
            text[8*(KW_MAX_CHARS-i)-1 -: 8] != KW_TEXT[k][8*(KW_MAX_CHARS-i)-1 -: 8]) begin
          same = 1'b0;
        end
      end
      if (same && !r.hit) begin
        r.hit  = 1'b1;
        r.code = KW_CODE_W'(k);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/akl_front.sv
`default_nettype none
`include "asm_keyword_lexer_assert.svh"

module akl_front #(
  parameter int MAX_WORD_LEN  = akl_pkg::AKL_MAX_WORD_LEN,
  parameter int POSITION_BITS = akl_pkg::AKL_POSITION_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     take,
  input  wire logic [7:0]               char_byte,
  input  wire logic                     end_of_text,
  output      logic                     push,
  output      akl_pkg::akl_tag_t        tag,
  output      logic [POSITION_BITS-1:0] word_line,
  output      logic [POSITION_BITS-1:0] word_column,
  output      logic [POSITION_BITS-1:0] digit_line,
  output      logic [POSITION_BITS-1:0] digit_column
);
  import akl_pkg::*;

  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int IW = $clog2(MAX_WORD_LEN);

  logic [7:0]               letters [MAX_WORD_LEN];
  logic [LW-1:0]            len;
  logic                     too_long;
  logic                     in_word;
  logic [POSITION_BITS-1:0] start_line;
  logic [POSITION_BITS-1:0] start_column;
  logic [POSITION_BITS-1:0] line;
  logic [POSITION_BITS-1:0] column;

  logic                     is_letter;
  logic                     is_digit;
  logic [LW-1:0]            base_len;
  logic                     base_too;
  logic                     store;
  logic [LW-1:0]            w_len;
  logic                     w_too;
  logic                     flush;
  logic                     len_fits;
  kw_text_t                 text;
  akl_hit_t                 hit;

  always_comb begin
    is_letter = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                (char_byte >= 8'h61 && char_byte <= 8'h7A);
    is_digit  = char_byte >= 8'h30 && char_byte <= 8'h39;
    base_len  = in_word ? len : '0;
    base_too  = in_word ? too_long : 1'b0;
    store     = is_letter && (base_len < LW'(MAX_WORD_LEN));
    w_len     = store ? base_len + 1'b1 : base_len;
    w_too     = base_too | (is_letter & ~store);
    flush     = is_letter ? end_of_text : in_word;
    for (int i = 0; i < KW_MAX_CHARS; i++) begin
      text[8*(KW_MAX_CHARS-i)-1 -: 8] =
        (store && base_len == LW'(i)) ? char_byte : letters[i];
    end
    len_fits = w_len <= LW'(KW_MAX_CHARS);
    hit      = kw_lookup(text, len_fits ? KW_LEN_W'(w_len) : '0);

    push             = take && (flush || is_digit);
    tag.word_valid   = flush;
    tag.word_kind    = (hit.hit && !w_too) ? KIND_KEYWORD : KIND_WORD;
    tag.word_code    = (hit.hit && !w_too) ? hit.code : '0;
    tag.digit_valid  = !is_letter && is_digit;
    word_line        = in_word ? start_line : line;
    word_column      = in_word ? start_column : column;
    digit_line       = line;
    digit_column     = column;
  end

  always_ff @(posedge clk) begin
    if (take && store) begin
      letters[base_len[IW-1:0]] <= char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      too_long     <= 1'b0;
      in_word      <= 1'b0;
      start_line   <= POSITION_BITS'(1);
      start_column <= POSITION_BITS'(1);
      line         <= POSITION_BITS'(1);
      column       <= POSITION_BITS'(1);
    end else if (take) begin
      if (is_letter && !flush) begin
        in_word      <= 1'b1;
        len          <= w_len;
        too_long     <= w_too;
        start_line   <= word_line;
        start_column <= word_column;
      end else begin
        in_word  <= 1'b0;
        len      <= '0;
        too_long <= 1'b0;
      end
      if (char_byte == NEWLINE_BYTE) begin
        line   <= (line == '1) ? line : line + 1'b1;
        column <= POSITION_BITS'(1);
      end else begin
        column <= (column == '1) ? column : column + 1'b1;
      end
    end
  end

  `AKL_ASSERT_NOW(fr_push_has_result, push, tag.word_valid || tag.digit_valid)
  `AKL_ASSERT_NOW(fr_word_has_letters, in_word, len != '0)

endmodule

`default_nettype wire

// File: hw/rtl/akl_queue.sv
`default_nettype none
`include "asm_keyword_lexer_assert.svh"

module akl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = akl_pkg::AKL_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output      logic             full,
  input  wire logic             pop,
  output      logic [WIDTH-1:0] rdata,
  output      logic             not_empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign rdata     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `AKL_ASSERT_NOW(q_no_overflow, push, !full)
  `AKL_ASSERT_NOW(q_no_underflow, pop, not_empty)

endmodule

`default_nettype wire

// File: hw/rtl/akl_back.sv
`default_nettype none
`include "asm_keyword_lexer_assert.svh"

module akl_back #(
  parameter int POSITION_BITS = akl_pkg::AKL_POSITION_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     head_valid,
  input  wire akl_pkg::akl_tag_t        head_tag,
  input  wire logic [POSITION_BITS-1:0] head_word_line,
  input  wire logic [POSITION_BITS-1:0] head_word_column,
  input  wire logic [POSITION_BITS-1:0] head_digit_line,
  input  wire logic [POSITION_BITS-1:0] head_digit_column,
  output      logic                     pop,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      akl_pkg::akl_kind_t       out_kind,
  output      logic [akl_pkg::KW_CODE_W-1:0] out_code,
  output      logic [POSITION_BITS-1:0] out_line,
  output      logic [POSITION_BITS-1:0] out_column,
  output      logic                     out_last
);
  import akl_pkg::*;

  logic                     phase;   // word part of the head entry already sent
  logic                     sel_word;
  logic                     cur_last;
  logic                     load;

  always_comb begin
    sel_word = head_tag.word_valid && !phase;
    cur_last = !(sel_word && head_tag.digit_valid);
    load     = head_valid && (!out_valid || out_ready);
    pop      = load && cur_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= sel_word ? head_tag.word_kind : KIND_DIGIT;
      out_code   <= sel_word ? head_tag.word_code : '0;
      out_line   <= sel_word ? head_word_line : head_digit_line;
      out_column <= sel_word ? head_word_column : head_digit_column;
      out_last   <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !cur_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `AKL_ASSERT_NOW(bk_phase_has_digit, phase, head_valid && head_tag.digit_valid)

endmodule

`default_nettype wire

// File: hw/rtl/asm_keyword_lexer.sv
// assembler keyword lexer
// s_axis carries source text, one byte per transaction; tlast marks the final
// byte of the source and flushes a word still pending after it.
// m_axis carries tokens: tuser is the kind (keyword, unknown word, digit),
// tdata holds the mnemonic code and the line and column where the token
// starts; tlast marks the last token caused by one input byte (a byte that
// ends a word and is itself a digit gives two tokens).
// throughput: one byte per cycle while the queue has space; a byte that gives two
// tokens sends them one after the other, and the four-entry queue between the
// classifying front end and the token emitter absorbs such bursts.
// path: a byte accepted at a clock edge is written to the queue at that same
// edge; its first token then goes to m_axis through the output register.
// bytes that give no token (spaces, punctuation, letters inside a word)
// never reach the queue.
// reset: line and column return to 1, no word pending, queue and output empty.
// a stall on m_axis fills the queue; s_axis_tready drops once it is full.
`default_nettype none

module asm_keyword_lexer #(
  parameter int MAX_WORD_LEN  = akl_pkg::AKL_MAX_WORD_LEN,
  parameter int POSITION_BITS = akl_pkg::AKL_POSITION_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // char_byte
  input  wire logic                   s_axis_tlast,   // end_of_text
  // token stream
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [((akl_pkg::KW_CODE_W + 2*POSITION_BITS + 7)/8)*8-1:0]
                                      m_axis_tdata,   // keyword_code, token_line,
                                                      // token_column, zero fill
  output      logic [1:0]             m_axis_tuser,   // token_kind
  output      logic                   m_axis_tlast    // last_of_run
);
  import akl_pkg::*;

  localparam int TDATA_W = ((KW_CODE_W + 2*POSITION_BITS + 7)/8)*8;
  localparam int TAG_W   = $bits(akl_tag_t);
  localparam int ENTRY_W = TAG_W + 4*POSITION_BITS;

  logic                     take;
  // front end to queue
  logic                     fr_push;
  akl_tag_t                 fr_tag;
  logic [POSITION_BITS-1:0] fr_word_line;
  logic [POSITION_BITS-1:0] fr_word_column;
  logic [POSITION_BITS-1:0] fr_digit_line;
  logic [POSITION_BITS-1:0] fr_digit_column;
  // queue head to emitter
  logic                     q_full;
  logic                     q_pop;
  logic                     q_valid;
  logic [ENTRY_W-1:0]       q_rdata;
  akl_tag_t                 hd_tag;
  logic [POSITION_BITS-1:0] hd_word_line;
  logic [POSITION_BITS-1:0] hd_word_column;
  logic [POSITION_BITS-1:0] hd_digit_line;
  logic [POSITION_BITS-1:0] hd_digit_column;
  // output register
  akl_kind_t                out_kind;
  logic [KW_CODE_W-1:0]     out_code;
  logic [POSITION_BITS-1:0] out_line;
  logic [POSITION_BITS-1:0] out_column;

  // the front end never waits on the emitter, only on queue space
  assign s_axis_tready = !q_full;
  assign take          = s_axis_tvalid && s_axis_tready;

  akl_front #(
    .MAX_WORD_LEN  (MAX_WORD_LEN),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .char_byte    (s_axis_tdata),
    .end_of_text  (s_axis_tlast),
    .push         (fr_push),
    .tag          (fr_tag),
    .word_line    (fr_word_line),
    .word_column  (fr_word_column),
    .digit_line   (fr_digit_line),
    .digit_column (fr_digit_column)
  );

  akl_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (AKL_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fr_push),
    .wdata     ({fr_tag, fr_word_line, fr_word_column, fr_digit_line, fr_digit_column}),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_valid)
  );

  assign {hd_tag, hd_word_line, hd_word_column, hd_digit_line, hd_digit_column} = q_rdata;

  akl_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (q_valid),
    .head_tag          (hd_tag),
    .head_word_line    (hd_word_line),
    .head_word_column  (hd_word_column),
    .head_digit_line   (hd_digit_line),
    .head_digit_column (hd_digit_column),
    .pop               (q_pop),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_kind          (out_kind),
    .out_code          (out_code),
    .out_line          (out_line),
    .out_column        (out_column),
    .out_last          (m_axis_tlast)
  );

  // code in the low bits, then line, then column, zero filled to whole bytes
  assign m_axis_tdata = TDATA_W'({out_column, out_line, out_code});
  assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire
